### src/clock_mode_controller_macros.svh
// Assertion macros shared by the clock mode controller RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef CLOCK_MODE_CONTROLLER_MACROS_SVH
`define CLOCK_MODE_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CMC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/cmc_pkg.sv
// Shared types and mode codes for the clock mode controller.
// No dependencies; used by cmc_next and clock_mode_controller.
package cmc_pkg;

  typedef logic [2:0] mode_t;

  localparam mode_t MODE_SET   = 3'd1;
  localparam mode_t MODE_24H   = 3'd2;
  localparam mode_t MODE_12H   = 3'd3;
  localparam mode_t MODE_LIGHT = 3'd4;
  localparam mode_t MODE_CELS  = 3'd5;
  localparam mode_t MODE_FAHR  = 3'd6;

  localparam logic [1:0] FIELD_HOUR   = 2'd1;
  localparam logic [1:0] FIELD_MINUTE = 2'd2;
  localparam logic [1:0] FIELD_SECOND = 2'd3;

  localparam logic [4:0] HOUR_NOON = 5'd12;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } time_t;

  typedef struct packed {
    mode_t      mode_now;
    mode_t      mode_default;
    time_t      tm;
    time_t      shadow;
    logic [1:0] field_sel;
    logic       started;
    logic       revert_running;
    logic [5:0] idle_count;
  } cmc_state_t;

endpackage

### src/cmc_next.sv
// Next-state logic of the clock mode controller: key presses and second ticks.
// Depends on cmc_pkg.
module cmc_next (
  input  cmc_pkg::cmc_state_t st,
  input  logic                command,
  input  logic [3:0]          key_code,
  input  logic [5:0]          timeout,
  output cmc_pkg::cmc_state_t st_nxt
);

  localparam logic [3:0] KEY_HOUR_FMT  = 4'd0;
  localparam logic [3:0] KEY_LIGHT     = 4'd1;
  localparam logic [3:0] KEY_TEMP      = 4'd2;
  localparam logic [3:0] KEY_CONFIRM   = 4'd3;
  localparam logic [3:0] KEY_FIELD_UP  = 4'd5;
  localparam logic [3:0] KEY_ADJ_UP    = 4'd8;
  localparam logic [3:0] KEY_ADJ_DOWN  = 4'd10;
  localparam logic [3:0] KEY_FIELD_DN  = 4'd13;
  localparam logic [3:0] KEY_SET       = 4'd15;

  localparam logic [5:0] HOUR_TOP = 6'd23;
  localparam logic [5:0] MS_TOP   = 6'd59;
  localparam logic [5:0] IDLE_MAX = 6'd63;

  localparam logic       CMD_TICK = 1'b1;

  // One second forward with carries; wider sums keep out-of-range values honest.
  function automatic cmc_pkg::time_t advance(input cmc_pkg::time_t t);
    logic [6:0]     s1;
    logic [6:0]     m1;
    logic [5:0]     h1;
    logic           mc;
    logic           hc;
    cmc_pkg::time_t r;
    s1 = {1'b0, t.seconds} + 7'd1;
    mc = (s1 >= 7'd60);
    m1 = {1'b0, t.minutes} + {6'd0, mc};
    hc = (m1 >= 7'd60);
    h1 = {1'b0, t.hours} + {5'd0, hc};
    r.seconds = mc ? 6'd0 : s1[5:0];
    r.minutes = hc ? 6'd0 : m1[5:0];
    r.hours   = (h1 >= 6'd24) ? 5'd0 : h1[4:0];
    return r;
  endfunction

  function automatic logic [5:0] step_val(input logic [5:0] v, input logic [5:0] top,
                                          input logic up);
    logic [5:0] r;
    if (up) begin
      r = (v >= top) ? 6'd0 : v + 6'd1;
    end else begin
      r = (v == 6'd0 || v > top) ? top : v - 6'd1;
    end
    return r;
  endfunction

  logic       was_default;
  logic       adj_up;
  logic [5:0] idle_inc;
  logic       restore;
  cmc_pkg::cmc_state_t s;

  always_comb begin
    s           = st;
    was_default = (st.mode_now == st.mode_default);
    adj_up      = (key_code == KEY_ADJ_UP);
    idle_inc    = 6'd0;
    restore     = 1'b0;

    if (command != CMD_TICK) begin
      s.idle_count = 6'd0;
      case (key_code)
        KEY_HOUR_FMT: begin
          s.mode_now = (st.mode_now == cmc_pkg::MODE_24H) ? cmc_pkg::MODE_12H
                                                          : cmc_pkg::MODE_24H;
        end
        KEY_LIGHT: s.mode_now = cmc_pkg::MODE_LIGHT;
        KEY_TEMP: begin
          s.mode_now = (st.mode_now == cmc_pkg::MODE_CELS) ? cmc_pkg::MODE_FAHR
                                                           : cmc_pkg::MODE_CELS;
        end
        KEY_CONFIRM: begin
          if (st.mode_now == cmc_pkg::MODE_SET) begin
            s.started  = 1'b1;
            s.mode_now = cmc_pkg::MODE_24H;
          end
          s.mode_default   = s.mode_now;
          s.revert_running = 1'b0;
        end
        KEY_FIELD_UP: begin
          s.field_sel = (st.field_sel >= cmc_pkg::FIELD_SECOND) ? cmc_pkg::FIELD_HOUR
                                                                : st.field_sel + 2'd1;
        end
        KEY_FIELD_DN: begin
          s.field_sel = (st.field_sel <= cmc_pkg::FIELD_HOUR) ? cmc_pkg::FIELD_SECOND
                                                              : st.field_sel - 2'd1;
        end
        KEY_ADJ_UP, KEY_ADJ_DOWN: begin
          if (st.mode_now == cmc_pkg::MODE_SET) begin
            s.revert_running = 1'b1;
          end
          case (st.field_sel)
            cmc_pkg::FIELD_HOUR: begin
              s.tm.hours = 5'(step_val({1'b0, st.tm.hours}, HOUR_TOP, adj_up));
            end
            cmc_pkg::FIELD_MINUTE: s.tm.minutes = step_val(st.tm.minutes, MS_TOP, adj_up);
            cmc_pkg::FIELD_SECOND: s.tm.seconds = step_val(st.tm.seconds, MS_TOP, adj_up);
            default: ;
          endcase
        end
        KEY_SET: begin
          s.mode_now       = cmc_pkg::MODE_SET;
          s.shadow         = st.tm;
          s.field_sel      = cmc_pkg::FIELD_HOUR;
          s.revert_running = 1'b1;
        end
        default: ;
      endcase
      if (s.mode_now != s.mode_default && was_default) begin
        s.revert_running = 1'b1;
      end
    end else begin
      // While setting, the shadow copy keeps running instead of the live time.
      if (st.started) begin
        if (st.mode_now != cmc_pkg::MODE_SET) begin
          s.tm = advance(st.tm);
        end else begin
          s.shadow = advance(st.shadow);
        end
      end
      if (st.revert_running) begin
        idle_inc     = (st.idle_count < IDLE_MAX) ? st.idle_count + 6'd1 : st.idle_count;
        s.idle_count = idle_inc;
        if (idle_inc >= timeout) begin
          restore = (st.mode_default == cmc_pkg::MODE_SET) ||
                    (st.mode_now == cmc_pkg::MODE_SET &&
                     (st.mode_default == cmc_pkg::MODE_24H ||
                      st.mode_default == cmc_pkg::MODE_12H));
          if (restore) begin
            s.field_sel = cmc_pkg::FIELD_HOUR;
            s.tm        = s.shadow;
          end
          s.mode_now       = st.mode_default;
          s.revert_running = 1'b0;
          s.idle_count     = 6'd0;
        end
      end
    end
    st_nxt = s;
  end

endmodule

### src/clock_mode_controller.sv
// Clock mode controller: usage notes.
// Input channel (in_valid/in_ready): one transfer carries in_command (0 key
// press, 1 one-second tick) and in_key_code. Each transfer updates the clock
// state and produces exactly one result transfer on the out_ channel with the
// displayed mode, time (hour folded in 12h mode), selected field, started flag
// and revert-armed flag.
// The result is registered: it is valid in the cycle after the input
// transfer. One item is accepted per cycle while out_ready keeps the result
// register draining; the next-state logic is a single combinational pass
// from the state registers into the state and result registers.
// in_ready is high whenever the result register is empty or being drained, so
// a stalled receiver holds the result and stops new inputs only while the one
// result register is full.
// User, not block, keeps cfg_wr_en/cfg_wr_data timeout reg writes to idle.
// Synchronous reset (rst_n low) puts the clock in set mode at 12:00:00,
// timeout 5, not started, revert timer running, and empties the result stage.
// Depends on cmc_pkg, cmc_next and clock_mode_controller_macros.svh.
`include "clock_mode_controller_macros.svh"

module clock_mode_controller (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_command,
  input  logic [3:0] in_key_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_mode,
  output logic [4:0] out_hour_shown,
  output logic [5:0] out_minute_shown,
  output logic [5:0] out_second_shown,
  output logic [1:0] out_selected_field,
  output logic       out_clock_started,
  output logic       out_revert_armed,
  input  logic       cfg_wr_en,
  input  logic [5:0] cfg_wr_data
);

  cmc_pkg::cmc_state_t st_r;
  cmc_pkg::cmc_state_t st_nxt;
  logic [5:0]          timeout_r;
  logic                out_valid_r;
  logic [2:0]          out_mode_r;
  logic [4:0]          out_hour_r;
  logic [5:0]          out_minute_r;
  logic [5:0]          out_second_r;
  logic [1:0]          out_field_r;
  logic                out_started_r;
  logic                out_armed_r;
  logic                in_fire;
  logic [4:0]          hour_nxt;

  cmc_next u_next (
    .st       (st_r),
    .command  (in_command),
    .key_code (in_key_code),
    .timeout  (timeout_r),
    .st_nxt   (st_nxt)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign hour_nxt = (st_nxt.mode_now == cmc_pkg::MODE_12H && st_nxt.tm.hours > cmc_pkg::HOUR_NOON)
                    ? st_nxt.tm.hours - cmc_pkg::HOUR_NOON : st_nxt.tm.hours;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode_now       <= cmc_pkg::MODE_SET;
      st_r.mode_default   <= cmc_pkg::MODE_SET;
      st_r.tm             <= '{hours: cmc_pkg::HOUR_NOON, minutes: 6'd0, seconds: 6'd0};
      st_r.shadow         <= '{hours: cmc_pkg::HOUR_NOON, minutes: 6'd0, seconds: 6'd0};
      st_r.field_sel      <= cmc_pkg::FIELD_HOUR;
      st_r.started        <= 1'b0;
      st_r.revert_running <= 1'b1;
      st_r.idle_count     <= 6'd0;
      timeout_r           <= 6'd5;
      out_valid_r         <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      if (in_fire) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload needs no reset; it is qualified by out_valid_r.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_mode_r    <= st_nxt.mode_now;
      out_hour_r    <= hour_nxt;
      out_minute_r  <= st_nxt.tm.minutes;
      out_second_r  <= st_nxt.tm.seconds;
      out_field_r   <= st_nxt.field_sel;
      out_started_r <= st_nxt.started;
      out_armed_r   <= st_nxt.revert_running;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_mode           = out_mode_r;
  assign out_hour_shown     = out_hour_r;
  assign out_minute_shown   = out_minute_r;
  assign out_second_shown   = out_second_r;
  assign out_selected_field = out_field_r;
  assign out_clock_started  = out_started_r;
  assign out_revert_armed   = out_armed_r;

  `CMC_ASSERT_NEXT(a_fire_gives_result, clk, rst_n, in_fire, out_valid_r, "transfer lost its result")
  `CMC_ASSERT_NEXT(a_started_sticks, clk, rst_n, st_r.started, st_r.started, "started flag cleared")
  `CMC_ASSERT_NOW(a_idle_needs_timer, clk, rst_n, !st_r.revert_running, st_r.idle_count == 6'd0, "idle count runs without timer")
  `CMC_ASSERT_NOW(a_field_valid, clk, rst_n, 1'b1, st_r.field_sel != 2'd0, "field selection is zero")
  `CMC_ASSERT_NOW(a_mode_valid, clk, rst_n, 1'b1, st_r.mode_now != 3'd0 && st_r.mode_now != 3'd7, "mode out of range")

endmodule
